// ===== src/tm_pkg.sv =====
// Shared types and field widths for the triangle metrics pipeline.
package tm_pkg;

    localparam int CENT_W  = 16;
    localparam int PERIM_W = 19;
    localparam int AREA_W  = 33;

    typedef struct packed {
        logic                      collinear;
        logic signed [CENT_W-1:0]  centroid_x;
        logic signed [CENT_W-1:0]  centroid_y;
        logic        [AREA_W-1:0]  area;
    } t_side;

endpackage

// ===== src/tm_front.sv =====
// Front pipeline: side deltas, squares, cross product and centroid (four stages).
module tm_front #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic signed [COORD_WIDTH-1:0] i_ax,
    input  logic signed [COORD_WIDTH-1:0] i_ay,
    input  logic signed [COORD_WIDTH-1:0] i_bx,
    input  logic signed [COORD_WIDTH-1:0] i_by_coord,
    input  logic signed [COORD_WIDTH-1:0] i_cx,
    input  logic signed [COORD_WIDTH-1:0] i_cy,
    output logic                          o_valid,
    output tm_pkg::t_side                 o_side,
    output logic [2*COORD_WIDTH+1:0]      o_sq_ab,
    output logic [2*COORD_WIDTH+1:0]      o_sq_ac,
    output logic [2*COORD_WIDTH+1:0]      o_sq_bc
);
    localparam int W   = COORD_WIDTH;
    localparam int DW  = W + 1;
    localparam int SW  = W + 2;
    localparam int PW  = 2 * W + 2;
    localparam int CW  = 2 * W + 3;
    localparam int K   = W + 2;
    localparam int MW  = W + 1;
    localparam int PRW = DW + MW;
    localparam logic [MW-1:0] RECIP = MW'(((64'd1 << K) - 64'd1) / 3);

    logic                 r1_v, r2_v, r3_v, r4_v;
    logic signed [DW-1:0] r1_dxab, r1_dyab, r1_dxac, r1_dyac, r1_dxbc, r1_dybc;
    logic signed [SW-1:0] r1_sx, r1_sy;
    logic signed [PW-1:0] r2_abx, r2_aby, r2_acx, r2_acy, r2_bcx, r2_bcy;
    logic signed [PW-1:0] r2_c1, r2_c2;
    logic        [DW-1:0] r2_mx, r2_my;
    logic                 r2_nx, r2_ny;
    logic        [PW-1:0] r3_ab, r3_ac, r3_bc;
    logic signed [CW-1:0] r3_cross;
    logic       [PRW-1:0] r3_px, r3_py;
    logic        [DW-1:0] r3_mx, r3_my;
    logic                 r3_nx, r3_ny;
    logic        [PW-1:0] r4_ab, r4_ac, r4_bc;
    tm_pkg::t_side        r4_side;
    logic        [CW-1:0] w_acr;
    tm_pkg::t_side        n_side;

    function automatic logic signed [tm_pkg::CENT_W-1:0] div3(
        input logic [PRW-1:0] prod,
        input logic [DW-1:0]  mag,
        input logic           neg
    );
        logic        [W-1:0]  q0;
        logic        [DW-1:0] rem;
        logic        [DW-1:0] q;
        logic signed [DW:0]   s;
        q0  = prod[PRW-1:K];
        rem = mag - (DW'(q0) << 1) - DW'(q0);
        q   = (rem >= DW'(3)) ? DW'(q0) + DW'(1) : DW'(q0);
        s   = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
        return tm_pkg::CENT_W'(s);
    endfunction

    always_comb begin
        w_acr             = r3_cross[CW-1] ? CW'(-r3_cross) : CW'(r3_cross);
        n_side.collinear  = (r3_cross == '0);
        n_side.centroid_x = div3(r3_px, r3_mx, r3_nx);
        n_side.centroid_y = div3(r3_py, r3_my, r3_ny);
        n_side.area       = tm_pkg::AREA_W'(w_acr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_dxab  <= DW'(i_bx) - DW'(i_ax);
            r1_dyab  <= DW'(i_by_coord) - DW'(i_ay);
            r1_dxac  <= DW'(i_cx) - DW'(i_ax);
            r1_dyac  <= DW'(i_cy) - DW'(i_ay);
            r1_dxbc  <= DW'(i_cx) - DW'(i_bx);
            r1_dybc  <= DW'(i_cy) - DW'(i_by_coord);
            r1_sx    <= SW'(i_ax) + SW'(i_bx) + SW'(i_cx);
            r1_sy    <= SW'(i_ay) + SW'(i_by_coord) + SW'(i_cy);

            r2_abx   <= r1_dxab * r1_dxab;
            r2_aby   <= r1_dyab * r1_dyab;
            r2_acx   <= r1_dxac * r1_dxac;
            r2_acy   <= r1_dyac * r1_dyac;
            r2_bcx   <= r1_dxbc * r1_dxbc;
            r2_bcy   <= r1_dybc * r1_dybc;
            r2_c1    <= r1_dxab * r1_dyac;
            r2_c2    <= r1_dxac * r1_dyab;
            r2_nx    <= r1_sx[SW-1];
            r2_ny    <= r1_sy[SW-1];
            r2_mx    <= r1_sx[SW-1] ? DW'(-r1_sx) : DW'(r1_sx);
            r2_my    <= r1_sy[SW-1] ? DW'(-r1_sy) : DW'(r1_sy);

            r3_ab    <= $unsigned(r2_abx) + $unsigned(r2_aby);
            r3_ac    <= $unsigned(r2_acx) + $unsigned(r2_acy);
            r3_bc    <= $unsigned(r2_bcx) + $unsigned(r2_bcy);
            r3_cross <= CW'(r2_c1) - CW'(r2_c2);
            r3_px    <= PRW'(r2_mx) * PRW'(RECIP);
            r3_py    <= PRW'(r2_my) * PRW'(RECIP);
            r3_mx    <= r2_mx;
            r3_my    <= r2_my;
            r3_nx    <= r2_nx;
            r3_ny    <= r2_ny;

            r4_ab    <= r3_ab;
            r4_ac    <= r3_ac;
            r4_bc    <= r3_bc;
            r4_side  <= n_side;
        end
    end

    assign o_valid = r4_v;
    assign o_side  = r4_side;
    assign o_sq_ab = r4_ab;
    assign o_sq_ac = r4_ac;
    assign o_sq_bc = r4_bc;

endmodule

// ===== src/tm_isqrt.sv =====
// Three-lane pipelined integer square root, one root bit per stage.
module tm_isqrt #(
    parameter int RW = 17
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  tm_pkg::t_side   i_side,
    input  logic [2*RW-1:0] i_n0,
    input  logic [2*RW-1:0] i_n1,
    input  logic [2*RW-1:0] i_n2,
    output logic            o_valid,
    output tm_pkg::t_side   o_side,
    output logic [RW-1:0]   o_root0,
    output logic [RW-1:0]   o_root1,
    output logic [RW-1:0]   o_root2
);
    localparam int NW = 2 * RW;

    logic                r_v    [RW];
    tm_pkg::t_side       r_side [RW];
    logic [NW-1:0]       r_rem  [RW][3];
    logic [RW-1:0]       r_root [RW][3];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        localparam int B = RW - 1 - k;
        logic [NW-1:0] w_rem  [3];
        logic [RW-1:0] w_root [3];
        logic [NW-1:0] w_trial[3];
        logic [NW-1:0] n_rem  [3];
        logic [RW-1:0] n_root [3];
        logic          w_v;
        tm_pkg::t_side w_side;

        if (k == 0) begin : g_first
            assign w_rem[0] = i_n0;
            assign w_rem[1] = i_n1;
            assign w_rem[2] = i_n2;
            assign w_root   = '{default: '0};
            assign w_v      = i_valid;
            assign w_side   = i_side;
        end else begin : g_next
            assign w_rem  = r_rem[k-1];
            assign w_root = r_root[k-1];
            assign w_v    = r_v[k-1];
            assign w_side = r_side[k-1];
        end

        always_comb begin
            for (int j = 0; j < 3; j++) begin
                w_trial[j] = (NW'(w_root[j]) << (B + 1)) | (NW'(1) << (2 * B));
                if (w_rem[j] >= w_trial[j]) begin
                    n_rem[j]  = w_rem[j] - w_trial[j];
                    n_root[j] = w_root[j] | (RW'(1) << B);
                end else begin
                    n_rem[j]  = w_rem[j];
                    n_root[j] = w_root[j];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_side[k] <= w_side;
            end
        end
    end

    assign o_valid = r_v[RW-1];
    assign o_side  = r_side[RW-1];
    assign o_root0 = r_root[RW-1][0];
    assign o_root1 = r_root[RW-1][1];
    assign o_root2 = r_root[RW-1][2];

endmodule

// ===== src/triangle_metrics.sv =====
// Top level: triangle perimeter, area and centroid pipeline with output register.
//
//  channel | valid   | stall   | word
//  --------+---------+---------+-----------------------------------------------
//  in      | i_valid | o_stall | i_ax i_ay i_bx i_by_coord i_cx i_cy
//  out     | o_valid | i_stall | o_collinear o_centroid_x o_centroid_y
//          |         |         | o_perimeter o_area
//
// One word per cycle while no stalled output word holds the pipeline; four front
// stages, COORD_WIDTH + 1 root stages and one output register.
// The root pipeline sets the depth: one root bit per stage.
// Reset clears every valid bit; payload registers are not reset.
// A stalled output word freezes the whole pipeline; o_stall is high then.
module triangle_metrics #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [COORD_WIDTH-1:0]     i_ax,
    input  logic signed [COORD_WIDTH-1:0]     i_ay,
    input  logic signed [COORD_WIDTH-1:0]     i_bx,
    input  logic signed [COORD_WIDTH-1:0]     i_by_coord,
    input  logic signed [COORD_WIDTH-1:0]     i_cx,
    input  logic signed [COORD_WIDTH-1:0]     i_cy,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_collinear,
    output logic signed [tm_pkg::CENT_W-1:0]  o_centroid_x,
    output logic signed [tm_pkg::CENT_W-1:0]  o_centroid_y,
    output logic [tm_pkg::PERIM_W-1:0]        o_perimeter,
    output logic [tm_pkg::AREA_W-1:0]         o_area
);
    localparam int RW = COORD_WIDTH + 1;
    localparam int NW = 2 * RW;

    logic                          w_en;
    logic                          w_fv, w_sv;
    tm_pkg::t_side                 w_fside, w_sside;
    logic [NW-1:0]                 w_sq_ab, w_sq_ac, w_sq_bc;
    logic [RW-1:0]                 w_r0, w_r1, w_r2;
    logic [RW+1:0]                 w_sum;
    logic                          r_ov;
    logic                          r_col;
    logic signed [tm_pkg::CENT_W-1:0] r_cx, r_cy;
    logic [tm_pkg::PERIM_W-1:0]    r_per;
    logic [tm_pkg::AREA_W-1:0]     r_area;

    assign o_stall = r_ov && i_stall;
    assign w_en    = !o_stall;

    tm_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (i_valid),
        .i_ax       (i_ax),
        .i_ay       (i_ay),
        .i_bx       (i_bx),
        .i_by_coord (i_by_coord),
        .i_cx       (i_cx),
        .i_cy       (i_cy),
        .o_valid    (w_fv),
        .o_side     (w_fside),
        .o_sq_ab    (w_sq_ab),
        .o_sq_ac    (w_sq_ac),
        .o_sq_bc    (w_sq_bc)
    );

    tm_isqrt #(.RW(RW)) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_fv),
        .i_side  (w_fside),
        .i_n0    (w_sq_ab),
        .i_n1    (w_sq_ac),
        .i_n2    (w_sq_bc),
        .o_valid (w_sv),
        .o_side  (w_sside),
        .o_root0 (w_r0),
        .o_root1 (w_r1),
        .o_root2 (w_r2)
    );

    assign w_sum = (RW+2)'(w_r0) + (RW+2)'(w_r1) + (RW+2)'(w_r2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= w_sv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_col  <= w_sside.collinear;
            r_cx   <= w_sside.collinear ? '0 : w_sside.centroid_x;
            r_cy   <= w_sside.collinear ? '0 : w_sside.centroid_y;
            r_area <= w_sside.collinear ? '0 : w_sside.area;
            r_per  <= w_sside.collinear ? '0 : tm_pkg::PERIM_W'(w_sum);
        end
    end

    assign o_valid      = r_ov;
    assign o_collinear  = r_col;
    assign o_centroid_x = r_cx;
    assign o_centroid_y = r_cy;
    assign o_perimeter  = r_per;
    assign o_area       = r_area;

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("valid set after reset");
    a_col_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_collinear |-> o_area == '0 && o_perimeter == '0
            && o_centroid_x == '0 && o_centroid_y == '0)
        else $error("collinear word with nonzero fields");
    a_area_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_collinear && COORD_WIDTH <= 16 |-> o_area != '0)
        else $error("non-collinear word with zero area");
    a_per_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_collinear && COORD_WIDTH <= 16 |-> o_perimeter != '0)
        else $error("non-collinear word with zero perimeter");

endmodule
